### hdl/edf_pkg.sv
// ----------------------------------------------------------------------------
// EDF scheduler package
// Shared widths, run-state codes, payload types and cell control types.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int TASK_COUNT = 8;
  localparam int TICK_BITS = 16;
  localparam int IDX_BITS = $clog2(TASK_COUNT);
  localparam int FIELD_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WAKE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_MARGIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_DOWN = 2'd2;

  localparam logic [FIELD_W-1:0] SEARCH_START = 16'd65535;
  localparam logic [FIELD_W-1:0] WAKE_START = 16'd60000;
  localparam logic [FIELD_W-1:0] EDGE_GUARD = 16'd2;

  typedef enum logic [1:0] {
    ST_FINISHED = 2'd0,
    ST_READY = 2'd1,
    ST_SUSPENDED = 2'd2,
    ST_EVENT = 2'd3
  } run_state_t;

  typedef struct packed {
    logic action;
    logic [2:0] task_index;
    logic task_enable;
    logic [15:0] task_period;
    logic [15:0] task_reserve;
    logic [15:0] start_delay;
    logic [15:0] elapsed_ticks;
    logic suspend_request;
    logic resource_wait;
    logic event_wait;
    logic wake_on_timer;
    logic [15:0] timer_now;
  } in_item_t;

  typedef struct packed {
    logic [2:0] next_task;
    logic [15:0] wake_ticks;
    logic task_switched;
    logic reserve_error;
    logic deadline_missed;
  } out_item_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic load;
    logic [IDX_BITS-1:0] load_idx;
    logic load_en;
    logic [TICK_BITS-1:0] load_period;
    logic [TICK_BITS-1:0] load_reserve;
    logic [TICK_BITS-1:0] load_delay;
    logic charge;
    logic [IDX_BITS-1:0] cur;
    logic susp_req;
    run_state_t susp_state;
    logic [TICK_BITS-1:0] elapsed;
    logic update;
  } cell_cmd_t;

  // Running values passed along the chain of cells.
  typedef struct packed {
    logic [TICK_BITS-1:0] best;
    logic [IDX_BITS-1:0] chosen;
    logic [TICK_BITS-1:0] chosen_budget;
    logic chosen_limited;
    logic [TICK_BITS-1:0] nw;
    logic missed;
    logic rerr;
  } chain_t;

endpackage

### hdl/edf_if.sv
// ----------------------------------------------------------------------------
// EDF stream interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface edf_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/edf_cell.sv
// ----------------------------------------------------------------------------
// EDF task cell
// Holds one task entry, charges, counts down and releases it, and folds its
// deadline into the running minimum passed along the chain.
// ----------------------------------------------------------------------------
module edf_cell (
  input  logic clk,
  input  logic rst_n,
  input  logic [edf_pkg::IDX_BITS-1:0] my_idx,
  input  edf_pkg::cell_cmd_t cmd,
  input  edf_pkg::chain_t chain_in,
  output edf_pkg::chain_t chain_out
);
  import edf_pkg::*;

  logic active_r, active_nxt;
  run_state_t st_r, st_nxt;
  logic [TICK_BITS-1:0] wake_r, wake_nxt, per_cd_r, per_cd_nxt;
  logic [TICK_BITS-1:0] bud_r, bud_nxt, plen_r, plen_nxt, res_r, res_nxt;
  logic [TICK_BITS:0] psum;
  logic [TICK_BITS-1:0] w1, e;
  logic is_cur;

  assign e = cmd.elapsed;
  assign is_cur = (cmd.cur == my_idx);
  assign psum = {1'b0, cmd.load_delay} + {1'b0, cmd.load_period};

  always_comb begin
    active_nxt = active_r;
    st_nxt = st_r;
    wake_nxt = wake_r;
    per_cd_nxt = per_cd_r;
    bud_nxt = bud_r;
    plen_nxt = plen_r;
    res_nxt = res_r;
    chain_out = chain_in;
    w1 = '0;
    if (cmd.load && cmd.load_idx == my_idx) begin
      active_nxt = cmd.load_en;
      st_nxt = cmd.load_en ? ST_SUSPENDED : ST_FINISHED;
      plen_nxt = cmd.load_period;
      res_nxt = cmd.load_reserve;
      bud_nxt = cmd.load_reserve;
      wake_nxt = cmd.load_delay;
      per_cd_nxt = psum[TICK_BITS] ? '1 : psum[TICK_BITS-1:0];
    end
    if (cmd.charge && is_cur) begin
      if (cmd.susp_req && st_r != ST_FINISHED) begin
        st_nxt = cmd.susp_state;
      end
      if (res_r != '0 && my_idx != '0 && st_nxt != ST_SUSPENDED &&
          st_nxt != ST_FINISHED) begin
        if (bud_r < e) begin
          chain_out.rerr = 1'b1;
          bud_nxt = '0;
        end else begin
          bud_nxt = bud_r - e;
        end
        if (bud_nxt == '0) begin
          st_nxt = ST_SUSPENDED;
        end
      end
    end
    if (cmd.update && active_r && my_idx != '0 && st_r != ST_FINISHED) begin
      w1 = (e >= wake_r) ? '0 : wake_r - e;
      wake_nxt = w1;
      if (e < per_cd_r) begin
        per_cd_nxt = per_cd_r - e;
      end else if (e > per_cd_r) begin
        chain_out.missed = 1'b1;
      end else begin
        per_cd_nxt = plen_r;
      end
      if (st_r == ST_SUSPENDED) begin
        if (w1 == '0) begin
          bud_nxt = res_r;
          st_nxt = ST_READY;
          wake_nxt = per_cd_nxt;
        end
        if (wake_nxt != '0 && wake_nxt < chain_in.nw) begin
          chain_out.nw = wake_nxt;
        end
      end
      if (st_nxt == ST_READY && per_cd_nxt < chain_in.best) begin
        chain_out.best = per_cd_nxt;
        chain_out.chosen = my_idx;
        chain_out.chosen_budget = bud_nxt;
        chain_out.chosen_limited = (res_r != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      st_r <= ST_FINISHED;
      wake_r <= '0;
      per_cd_r <= '0;
      bud_r <= '0;
      plen_r <= '0;
      res_r <= '0;
    end else begin
      active_r <= active_nxt;
      st_r <= st_nxt;
      wake_r <= wake_nxt;
      per_cd_r <= per_cd_nxt;
      bud_r <= bud_nxt;
      plen_r <= plen_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

### hdl/periodic_task_edf_scheduler_core.sv
// ----------------------------------------------------------------------------
// Periodic task EDF scheduler core
// A load transfer writes the task entry in the charge state and then presents
// its result. A schedule transfer charges the running task, walks the running
// minimum along the chain of task cells, visiting each cell in turn, clamps the
// timer interval and presents the result. The result sits in an output register;
// the next input transfer is taken once it has been handed on.
// ----------------------------------------------------------------------------
module periodic_task_edf_scheduler_core (
  input  logic clk,
  input  logic rst_n,
  edf_if.sink in_ch,
  edf_if.source out_ch,
  input  logic cfg_we,
  input  logic [edf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [edf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import edf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHARGE, S_WALK, S_CLAMP, S_OUT} fsm_t;

  fsm_t state_r;
  in_item_t item_r;
  out_item_t res_r;
  logic out_valid_r;
  logic [IDX_BITS-1:0] step_r, cur_r;
  logic [TICK_BITS-1:0] max_wake_r, margin_r;
  logic pd_en_r;
  chain_t acc_r;
  cell_cmd_t cmd;
  chain_t chain_in [TASK_COUNT];
  chain_t chain_out [TASK_COUNT];
  logic [TICK_BITS-1:0] nw, d, smm;
  logic [TICK_BITS:0] s_plus_m, tnow1;

  assign in_ch.ready = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = res_r;

  always_comb begin
    cmd = '0;
    cmd.load_idx = item_r.task_index;
    cmd.load_en = item_r.task_enable;
    cmd.load_period = item_r.task_period;
    cmd.load_reserve = item_r.task_reserve;
    cmd.load_delay = item_r.start_delay;
    cmd.cur = cur_r;
    cmd.susp_req = item_r.suspend_request;
    if (item_r.resource_wait || (item_r.event_wait && !item_r.wake_on_timer)) begin
      cmd.susp_state = ST_EVENT;
    end else begin
      cmd.susp_state = ST_SUSPENDED;
    end
    cmd.elapsed = item_r.elapsed_ticks;
    cmd.charge = (state_r == S_CHARGE);
    cmd.load = (state_r == S_CHARGE) && !item_r.action;
    cmd.update = (state_r == S_WALK);
  end

  genvar g;
  generate
    for (g = 0; g < TASK_COUNT; g++) begin : g_cell
      cell_cmd_t c;
      always_comb begin
        c = cmd;
        c.update = cmd.update && (step_r == IDX_BITS'(g));
        c.charge = cmd.charge && item_r.action;
        chain_in[g] = acc_r;
      end
      edf_cell u_cell (
        .clk(clk), .rst_n(rst_n), .my_idx(IDX_BITS'(g)),
        .cmd(c), .chain_in(chain_in[g]), .chain_out(chain_out[g])
      );
    end
  endgenerate

  assign s_plus_m = {1'b0, margin_r} + {1'b0, max_wake_r};
  assign d = acc_r.nw - margin_r;
  assign smm = max_wake_r - margin_r;
  assign tnow1 = {1'b0, item_r.timer_now} + 17'd1;

  always_comb begin
    nw = acc_r.nw;
    if (acc_r.chosen != '0) begin
      if (acc_r.chosen_limited && acc_r.chosen_budget < max_wake_r) begin
        if (acc_r.chosen_budget < nw) nw = acc_r.chosen_budget;
      end else if (nw > max_wake_r) begin
        nw = max_wake_r;
      end
    end else if (pd_en_r) begin
      if (acc_r.nw > margin_r) begin
        if (d < max_wake_r) begin
          nw = (d < margin_r) ? margin_r - 16'd1 : d;
        end else if ({1'b0, acc_r.nw} > s_plus_m) begin
          nw = max_wake_r;
        end else begin
          nw = smm;
        end
      end
    end
    if (!pd_en_r && nw > max_wake_r) nw = max_wake_r;
    if (tnow1 >= {1'b0, nw}) nw = item_r.timer_now + EDGE_GUARD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      cur_r <= '0;
      step_r <= '0;
      max_wake_r <= 16'd250;
      margin_r <= 16'd10;
      pd_en_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_WAKE: max_wake_r <= cfg_data;
          CFG_SLEEP_MARGIN: margin_r <= cfg_data;
          CFG_POWER_DOWN: pd_en_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            item_r <= in_ch.data;
            acc_r <= '{best: SEARCH_START, nw: WAKE_START, default: '0};
            state_r <= S_CHARGE;
          end
        end
        S_CHARGE: begin
          step_r <= '0;
          if (!item_r.action) begin
            res_r <= '{next_task: cur_r, default: '0};
            state_r <= S_OUT;
          end else begin
            acc_r.rerr <= chain_out[cur_r].rerr;
            state_r <= S_WALK;
          end
        end
        S_WALK: begin
          acc_r <= chain_out[step_r];
          step_r <= step_r + 1'b1;
          if (step_r == IDX_BITS'(TASK_COUNT - 1)) state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          res_r <= '{next_task: acc_r.chosen, wake_ticks: nw,
                     task_switched: (acc_r.chosen != cur_r),
                     reserve_error: acc_r.rerr, deadline_missed: acc_r.missed};
          cur_r <= acc_r.chosen;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT) else $error("bad result timing");
  a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !item_r.action |-> res_r.wake_ticks == '0)
    else $error("load result not zero");

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// EDF scheduler core testbench
// Drives load and schedule transfers through the input channel, predicts
// each result with an in-bench model of the task table or a directed row,
// and compares every result transfer field by field. Runs several register
// settings and idling patterns, with a long stall of the result channel.
// ----------------------------------------------------------------------------
module tb;
  import edf_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct {
    in_item_t item;
    bit typed;
    out_item_t res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  edf_if #(.payload_t(in_item_t)) in_ch (clk);
  edf_if #(.payload_t(out_item_t)) out_ch (clk);

  periodic_task_edf_scheduler_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Scheduler state as predicted by the bench.
  bit task_active [TASK_COUNT];
  run_state_t run_st [TASK_COUNT];
  int unsigned wake_cd [TASK_COUNT];
  int unsigned period_cd [TASK_COUNT];
  int unsigned budget [TASK_COUNT];
  int unsigned period_len [TASK_COUNT];
  int unsigned reserve [TASK_COUNT];
  int unsigned current_task;
  int unsigned max_wake;
  int unsigned sleep_margin;
  bit power_down;

  out_item_t pending_results [$];
  stim_row_t directed [$];
  int errors;
  int unsigned cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_req;
  int hold_done;
  int hold_cnt;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t schedule_step(in_item_t it);
    out_item_t r;
    int unsigned e, tnow, cur, nw, best, chosen, d, idx, sum;
    bit rerr, missed;
    r = '0;
    if (!it.action) begin
      idx = 32'(it.task_index);
      task_active[idx] = it.task_enable;
      run_st[idx] = it.task_enable ? ST_SUSPENDED : ST_FINISHED;
      period_len[idx] = 32'(it.task_period);
      reserve[idx] = 32'(it.task_reserve);
      budget[idx] = 32'(it.task_reserve);
      wake_cd[idx] = 32'(it.start_delay);
      sum = 32'(it.start_delay) + 32'(it.task_period);
      period_cd[idx] = (sum > 65535) ? 65535 : sum;
      r.next_task = current_task[2:0];
      return r;
    end
    e = 32'(it.elapsed_ticks);
    tnow = 32'(it.timer_now);
    cur = current_task;
    nw = 32'(WAKE_START);
    best = 32'(SEARCH_START);
    chosen = 0;
    rerr = 1'b0;
    missed = 1'b0;
    if (it.suspend_request && run_st[cur] != ST_FINISHED) begin
      if (it.resource_wait) run_st[cur] = ST_EVENT;
      else if (it.event_wait && !it.wake_on_timer) run_st[cur] = ST_EVENT;
      else run_st[cur] = ST_SUSPENDED;
    end
    if (reserve[cur] != 0 && cur != 0 && run_st[cur] != ST_SUSPENDED &&
        run_st[cur] != ST_FINISHED) begin
      if (budget[cur] < e) begin
        rerr = 1'b1;
        budget[cur] = 0;
      end else begin
        budget[cur] -= e;
      end
      if (budget[cur] == 0) run_st[cur] = ST_SUSPENDED;
    end
    for (int i = 1; i < TASK_COUNT; i++) begin
      if (!task_active[i] || run_st[i] == ST_FINISHED) continue;
      wake_cd[i] = (e >= wake_cd[i]) ? 0 : wake_cd[i] - e;
      if (e < period_cd[i]) period_cd[i] -= e;
      else if (e > period_cd[i]) missed = 1'b1;
      else period_cd[i] = period_len[i];
      if (run_st[i] == ST_SUSPENDED) begin
        if (wake_cd[i] == 0) begin
          budget[i] = reserve[i];
          run_st[i] = ST_READY;
          wake_cd[i] = period_cd[i];
        end
        if (wake_cd[i] != 0 && wake_cd[i] < nw) nw = wake_cd[i];
      end
    end
    for (int i = 1; i < TASK_COUNT; i++) begin
      if (task_active[i] && run_st[i] == ST_READY && period_cd[i] < best) begin
        best = period_cd[i];
        chosen = i;
      end
    end
    if (chosen != 0) begin
      if (reserve[chosen] != 0 && budget[chosen] < max_wake) begin
        if (budget[chosen] < nw) nw = budget[chosen];
      end else if (nw > max_wake) begin
        nw = max_wake;
      end
    end else if (power_down) begin
      if (nw > sleep_margin) begin
        d = nw - sleep_margin;
        if (d < max_wake) nw = (d < sleep_margin) ? sleep_margin - 1 : d;
        else if (nw > sleep_margin + max_wake) nw = max_wake;
        else nw = (max_wake - sleep_margin) & 32'hFFFF;
      end
    end
    if (!power_down && nw > max_wake) nw = max_wake;
    if (tnow + 1 >= nw) nw = (tnow + 32'(EDGE_GUARD)) & 32'hFFFF;
    r.next_task = chosen[2:0];
    r.wake_ticks = nw[15:0];
    r.task_switched = (chosen != cur);
    r.reserve_error = rerr;
    r.deadline_missed = missed;
    current_task = chosen;
    return r;
  endfunction

  function automatic in_item_t load_item(int idx, bit en, int per, int res, int dly);
    in_item_t it;
    it = '0;
    it.task_index = idx[2:0];
    it.task_enable = en;
    it.task_period = per[15:0];
    it.task_reserve = res[15:0];
    it.start_delay = dly[15:0];
    return it;
  endfunction

  function automatic in_item_t sched_item(int e, bit sus, bit rw, bit ew, bit wt, int tn);
    in_item_t it;
    it = '0;
    it.action = 1'b1;
    it.elapsed_ticks = e[15:0];
    it.suspend_request = sus;
    it.resource_wait = rw;
    it.event_wait = ew;
    it.wake_on_timer = wt;
    it.timer_now = tn[15:0];
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.action = ($urandom_range(99) >= 25);
    if (!it.action) begin
      it.task_enable = ($urandom_range(99) < 85);
      it.task_period = 16'(($urandom_range(9) == 0) ? $urandom_range(65535, 1)
                                                     : $urandom_range(200, 1));
      it.task_reserve = 16'(($urandom_range(2) == 0) ? 0 :
                            ($urandom_range(9) == 0) ? $urandom_range(65535)
                                                     : $urandom_range(100, 1));
      it.start_delay = 16'(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                    : $urandom_range(100));
    end else begin
      it.elapsed_ticks = 16'(($urandom_range(9) == 0) ? $urandom_range(65535)
                                                      : $urandom_range(30));
      it.suspend_request = ($urandom_range(99) < 20);
      it.timer_now = 16'(($urandom_range(4) == 0) ? $urandom_range(65535)
                                                  : $urandom_range(300));
    end
    return it;
  endfunction

  task automatic send(in_item_t it, bit typed, out_item_t res);
    out_item_t predicted;
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    predicted = schedule_step(it);
    pending_results.push_back(typed ? res : predicted);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_config(int unsigned mw, int unsigned sm, bit pd);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_MAX_WAKE;
    cfg_data <= mw[15:0];
    @(posedge clk);
    cfg_index <= CFG_SLEEP_MARGIN;
    cfg_data <= sm[15:0];
    @(posedge clk);
    cfg_index <= CFG_POWER_DOWN;
    cfg_data <= {15'd0, pd};
    @(posedge clk);
    cfg_we <= 1'b0;
    max_wake = mw;
    sleep_margin = sm;
    power_down = pd;
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_done) begin
      hold_done <= hold_req;
      hold_cnt <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer %p", out_ch.data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.data.next_task !== want.next_task) begin
          $error("next_task: expected %0d, got %0d", want.next_task, out_ch.data.next_task);
          errors++;
        end
        if (out_ch.data.wake_ticks !== want.wake_ticks) begin
          $error("wake_ticks: expected %0d, got %0d", want.wake_ticks,
                 out_ch.data.wake_ticks);
          errors++;
        end
        if (out_ch.data.task_switched !== want.task_switched) begin
          $error("task_switched: expected %0b, got %0b", want.task_switched,
                 out_ch.data.task_switched);
          errors++;
        end
        if (out_ch.data.reserve_error !== want.reserve_error) begin
          $error("reserve_error: expected %0b, got %0b", want.reserve_error,
                 out_ch.data.reserve_error);
          errors++;
        end
        if (out_ch.data.deadline_missed !== want.deadline_missed) begin
          $error("deadline_missed: expected %0b, got %0b", want.deadline_missed,
                 out_ch.data.deadline_missed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL periodic_task_edf_scheduler_core");
      $finish;
    end
  end

  initial begin
    int unsigned mw_set [6] = '{250, 65535, 1, 100, 65535, 40};
    int unsigned sm_set [6] = '{10, 0, 65535, 200, 65535, 30};
    bit pd_set [6] = '{1, 1, 1, 0, 0, 1};
    int idle_mode [4][2] = '{'{0, 0}, '{83, 0}, '{0, 83}, '{27, 27}};
    out_item_t none;
    stim_row_t row;
    errors = 0;
    cycles = 0;
    hold_req = 0;
    hold_done = 0;
    hold_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MAX_WAKE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      task_active[i] = 1'b0;
      run_st[i] = ST_FINISHED;
      wake_cd[i] = 0;
      period_cd[i] = 0;
      budget[i] = 0;
      period_len[i] = 0;
      reserve[i] = 0;
    end
    current_task = 0;
    max_wake = 250;
    sleep_margin = 10;
    power_down = 1'b1;
    none = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row.typed = 1'b1;
    row.res = '{next_task: 3'd0, wake_ticks: 16'd250, default: '0};
    row.item = sched_item(0, 0, 0, 0, 0, 0);
    directed.push_back(row);
    row.res = '{next_task: 3'd0, wake_ticks: 16'd1, default: '0};
    row.item = sched_item(0, 0, 0, 0, 0, 65535);
    directed.push_back(row);
    row.res = none;
    row.item = load_item(1, 1, 100, 20, 0);
    directed.push_back(row);
    row.item = load_item(2, 1, 65535, 0, 65535);
    directed.push_back(row);
    row.item = load_item(0, 1, 5, 5, 0);
    directed.push_back(row);
    row.item = load_item(3, 0, 50, 10, 5);
    directed.push_back(row);
    row.item = load_item(4, 1, 30, 10, 3);
    directed.push_back(row);
    row.typed = 1'b0;
    row.item = sched_item(0, 0, 0, 0, 0, 0);
    directed.push_back(row);
    row.item = sched_item(15, 0, 0, 0, 0, 10);
    directed.push_back(row);
    row.item = sched_item(10, 0, 0, 0, 0, 20);
    directed.push_back(row);
    row.item = sched_item(3, 1, 1, 0, 0, 5);
    directed.push_back(row);
    row.item = sched_item(2, 1, 0, 1, 0, 5);
    directed.push_back(row);
    row.item = sched_item(40, 1, 0, 1, 1, 5);
    directed.push_back(row);
    row.item = load_item(5, 1, 7, 0, 0);
    directed.push_back(row);
    row.item = sched_item(7, 0, 0, 0, 0, 0);
    directed.push_back(row);
    row.item = sched_item(7, 1, 0, 0, 0, 0);
    directed.push_back(row);
    row.item = sched_item(65535, 0, 0, 0, 0, 0);
    directed.push_back(row);
    row.item = sched_item(0, 0, 0, 0, 0, 65534);
    directed.push_back(row);
    row.item = load_item(7, 1, 1, 65535, 0);
    directed.push_back(row);
    row.item = sched_item(1, 0, 0, 0, 0, 1);
    directed.push_back(row);

    write_config(mw_set[0], sm_set[0], pd_set[0]);
    foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      write_config(mw_set[ph], sm_set[ph], pd_set[ph]);
      for (int k = 0; k < 190; k++) begin
        if (k % 48 == 0) begin
          send_idle_pct = idle_mode[(ph + k / 48) % 4][0];
          recv_stall_pct = idle_mode[(ph + k / 48) % 4][1];
        end
        if (ph == 1 && k == 100) begin
          send_idle_pct = 0;
          hold_req++;
        end
        send(random_item(), 1'b0, none);
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS periodic_task_edf_scheduler_core");
    end else begin
      $display("FAIL periodic_task_edf_scheduler_core");
    end
    $finish;
  end
endmodule

### periodic_task_edf_scheduler_core.f
hdl/edf_pkg.sv
hdl/edf_if.sv
hdl/edf_cell.sv
hdl/periodic_task_edf_scheduler_core.sv
dv/tb.sv
